[design/nce_pkg.sv]
// shared types, constants and helper functions of the neighbor cell enumerator
package nce_pkg;

    localparam int MAX_CELLS_PER_AXIS = 64;
    localparam int COORD_W            = 6;
    localparam int SIZE_W             = 7;
    localparam int HOME_W             = 18;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 7;
    localparam int QUEUE_DEPTH        = 2;
    localparam int QUEUE_PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_TDATA_W         = 24;
    localparam int OUT_TDATA_W        = 40;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CELLS_X    = 3'd0,
        CFG_CELLS_Y    = 3'd1,
        CFG_CELLS_Z    = 3'd2,
        CFG_PERIODIC_X = 3'd3,
        CFG_PERIODIC_Y = 3'd4,
        CFG_PERIODIC_Z = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [SIZE_W-1:0] cells_x;
        logic [SIZE_W-1:0] cells_y;
        logic [SIZE_W-1:0] cells_z;
        logic              periodic_x;
        logic              periodic_y;
        logic              periodic_z;
    } t_cfg;

    // up to three distinct neighbor coordinates on one axis, first cnt valid
    typedef struct packed {
        logic [COORD_W-1:0] v0;
        logic [COORD_W-1:0] v1;
        logic [COORD_W-1:0] v2;
        logic [1:0]         cnt;
    } t_axis_list;

    typedef struct packed {
        t_axis_list        x;
        t_axis_list        y;
        t_axis_list        z;
        logic [HOME_W-1:0] home;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] reg_val);
        logic [SIZE_W-1:0] n;
        n = reg_val;
        if (reg_val == '0) begin
            n = SIZE_W'(1);
        end else if (reg_val > SIZE_W'(MAX_CELLS_PER_AXIS)) begin
            n = SIZE_W'(MAX_CELLS_PER_AXIS);
        end
        return n;
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(logic [COORD_W-1:0] c,
                                                     logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0] nm1;
        nm1 = n - SIZE_W'(1);
        return ({1'b0, c} >= n) ? nm1[COORD_W-1:0] : c;
    endfunction

    // distinct candidates c-1, c, c+1 along one axis, in first-seen order
    function automatic t_axis_list axis_list(logic [COORD_W-1:0] c,
                                             logic [SIZE_W-1:0] n,
                                             logic per);
        t_axis_list         l;
        logic               at_lo;
        logic               at_hi;
        logic [SIZE_W-1:0]  nm1;
        logic [COORD_W-1:0] lo;
        nm1   = n - SIZE_W'(1);
        at_lo = (c == '0);
        at_hi = ({1'b0, c} == nm1);
        if (per) begin
            l.v0 = at_lo ? nm1[COORD_W-1:0] : c - COORD_W'(1);
            l.v1 = c;
            l.v2 = at_hi ? '0 : c + COORD_W'(1);
            if (n == SIZE_W'(1)) begin
                l.cnt = 2'd1;
            end else if (n == SIZE_W'(2)) begin
                l.cnt = 2'd2;
            end else begin
                l.cnt = 2'd3;
            end
        end else begin
            lo    = at_lo ? c : c - COORD_W'(1);
            l.v0  = lo;
            l.v1  = lo + COORD_W'(1);
            l.v2  = lo + COORD_W'(2);
            l.cnt = 2'd3 - {1'b0, at_lo} - {1'b0, at_hi};
        end
        return l;
    endfunction

    function automatic logic [COORD_W-1:0] pick(t_axis_list l, logic [1:0] idx);
        logic [COORD_W-1:0] v;
        case (idx)
            2'd0:    v = l.v0;
            2'd1:    v = l.v1;
            default: v = l.v2;
        endcase
        return v;
    endfunction

endpackage

[design/neighbor_cell_enumerator.sv]
// top level: one request cycles through 1 to 27 neighbor results, one per clock
//   unless the output stalls; a request passes both front stages, the queue and the
//   output register before its first result is valid
// throughput: one result per cycle unless the output stalls, set by the back walker
// the front keeps accepting until the two-entry queue and both front stages are full
// reset: synchronous active low, clears pipeline, queue and walker; sizes reset to 1,
//   wrapping off
module neighbor_cell_enumerator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [nce_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [nce_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // cell_x[5:0], cell_y[11:6], cell_z[17:12], zero fill
    input  logic [nce_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // nbr_x[5:0], nbr_y[11:6], nbr_z[17:12], home_index[35:18], zero fill
    output logic [nce_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast
);

    localparam int C = nce_pkg::COORD_W;

    nce_pkg::t_cfg       r_cfg;
    nce_pkg::t_item      front_item, head_item;
    nce_pkg::t_q_status  q_status;
    logic                q_push, q_pop;
    logic [C-1:0]        nbr_x, nbr_y, nbr_z;
    logic [nce_pkg::HOME_W-1:0] home;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cells_x    <= nce_pkg::SIZE_W'(1);
            r_cfg.cells_y    <= nce_pkg::SIZE_W'(1);
            r_cfg.cells_z    <= nce_pkg::SIZE_W'(1);
            r_cfg.periodic_x <= 1'b0;
            r_cfg.periodic_y <= 1'b0;
            r_cfg.periodic_z <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                nce_pkg::CFG_CELLS_X:    r_cfg.cells_x    <= i_cfg_data;
                nce_pkg::CFG_CELLS_Y:    r_cfg.cells_y    <= i_cfg_data;
                nce_pkg::CFG_CELLS_Z:    r_cfg.cells_z    <= i_cfg_data;
                nce_pkg::CFG_PERIODIC_X: r_cfg.periodic_x <= i_cfg_data[0];
                nce_pkg::CFG_PERIODIC_Y: r_cfg.periodic_y <= i_cfg_data[0];
                nce_pkg::CFG_PERIODIC_Z: r_cfg.periodic_z <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    nce_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_cell_x (s_axis_tdata[C-1:0]),
        .i_cell_y (s_axis_tdata[2*C-1:C]),
        .i_cell_z (s_axis_tdata[3*C-1:2*C]),
        .i_q      (q_status),
        .o_push   (q_push),
        .o_item   (front_item)
    );

    nce_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (front_item),
        .i_pop    (q_pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    nce_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (head_item),
        .i_q      (q_status),
        .o_pop    (q_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_nbr_x  (nbr_x),
        .o_nbr_y  (nbr_y),
        .o_nbr_z  (nbr_z),
        .o_home   (home),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, home, nbr_z, nbr_y, nbr_x};

    // queue never written when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("queue push while full");

    // queue never read when empty
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue pop while empty");

    // retiring a request always puts its final result on the output
    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (m_axis_tvalid && m_axis_tlast))
        else $error("request retired without a last result");

endmodule

[design/nce_front.sv]
// front end: saturates the home cell, builds per-axis neighbor lists and the home index
module nce_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  nce_pkg::t_cfg                  i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [nce_pkg::COORD_W-1:0]    i_cell_x,
    input  logic [nce_pkg::COORD_W-1:0]    i_cell_y,
    input  logic [nce_pkg::COORD_W-1:0]    i_cell_z,
    input  nce_pkg::t_q_status             i_q,
    output logic                           o_push,
    output nce_pkg::t_item                 o_item
);

    localparam int NXHY_W = nce_pkg::SIZE_W + nce_pkg::COORD_W;
    localparam int NXY_W  = 2 * nce_pkg::SIZE_W;
    localparam int SUM_W  = NXY_W + nce_pkg::COORD_W + 1;

    logic [nce_pkg::SIZE_W-1:0]  nx, ny, nz;
    logic [nce_pkg::COORD_W-1:0] hx, hy, hz;
    logic                        s2_ready;
    logic [SUM_W-1:0]            home_sum;

    logic                        r_s1_valid;
    nce_pkg::t_axis_list         r_s1_x, r_s1_y, r_s1_z;
    logic [nce_pkg::COORD_W-1:0] r_s1_hx, r_s1_hz;
    logic [NXHY_W-1:0]           r_s1_nxhy;
    logic [NXY_W-1:0]            r_s1_nxy;

    logic                        r_s2_valid;
    nce_pkg::t_item              r_s2_item;

    always_comb begin
        nx = nce_pkg::eff_size(i_cfg.cells_x);
        ny = nce_pkg::eff_size(i_cfg.cells_y);
        nz = nce_pkg::eff_size(i_cfg.cells_z);
        hx = nce_pkg::sat_coord(i_cell_x, nx);
        hy = nce_pkg::sat_coord(i_cell_y, ny);
        hz = nce_pkg::sat_coord(i_cell_z, nz);
    end

    assign s2_ready = !r_s2_valid || !i_q.full;
    assign o_ready  = !r_s1_valid || s2_ready;
    assign o_push   = r_s2_valid && !i_q.full;
    assign o_item   = r_s2_item;

    // x + nx*y + nx*ny*z, the two products split across the stages
    assign home_sum = SUM_W'(r_s1_hx) + SUM_W'(r_s1_nxhy)
                    + SUM_W'(r_s1_nxy) * SUM_W'(r_s1_hz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_x    <= nce_pkg::axis_list(hx, nx, i_cfg.periodic_x);
            r_s1_y    <= nce_pkg::axis_list(hy, ny, i_cfg.periodic_y);
            r_s1_z    <= nce_pkg::axis_list(hz, nz, i_cfg.periodic_z);
            r_s1_hx   <= hx;
            r_s1_hz   <= hz;
            r_s1_nxhy <= nx * hy;
            r_s1_nxy  <= nx * ny;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_item.x    <= r_s1_x;
            r_s2_item.y    <= r_s1_y;
            r_s2_item.z    <= r_s1_z;
            r_s2_item.home <= home_sum[nce_pkg::HOME_W-1:0];
        end
    end

endmodule

[design/nce_queue.sv]
// short flop-based fifo of classified requests between front and back
module nce_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  nce_pkg::t_item     i_item,
    input  logic               i_pop,
    output nce_pkg::t_item     o_item,
    output nce_pkg::t_q_status o_status
);

    nce_pkg::t_item                     r_mem [nce_pkg::QUEUE_DEPTH];
    logic [nce_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [nce_pkg::QUEUE_CNT_W-1:0]    r_count;

    assign o_status.full  = (r_count == nce_pkg::QUEUE_CNT_W'(nce_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rd_ptr];

    function automatic logic [nce_pkg::QUEUE_PTR_W-1:0] ptr_inc(
            logic [nce_pkg::QUEUE_PTR_W-1:0] p);
        return (p == nce_pkg::QUEUE_PTR_W'(nce_pkg::QUEUE_DEPTH - 1)) ? '0
               : p + nce_pkg::QUEUE_PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + nce_pkg::QUEUE_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - nce_pkg::QUEUE_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[design/nce_back.sv]
// back end: walks the neighbor lists of the head request and drives the output register
module nce_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  nce_pkg::t_item                 i_item,
    input  nce_pkg::t_q_status             i_q,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [nce_pkg::COORD_W-1:0]    o_nbr_x,
    output logic [nce_pkg::COORD_W-1:0]    o_nbr_y,
    output logic [nce_pkg::COORD_W-1:0]    o_nbr_z,
    output logic [nce_pkg::HOME_W-1:0]     o_home,
    output logic                           o_last
);

    logic [1:0] r_ix, r_iy, r_iz;
    logic [1:0] n_ix, n_iy, n_iz;
    logic       load, x_end, y_end, z_end, all_end;

    logic                        r_out_valid;
    logic [nce_pkg::COORD_W-1:0] r_nbr_x, r_nbr_y, r_nbr_z;
    logic [nce_pkg::HOME_W-1:0]  r_home;
    logic                        r_last;

    always_comb begin
        load    = !i_q.empty && (!r_out_valid || i_ready);
        x_end   = (r_ix == i_item.x.cnt - 2'd1);
        y_end   = (r_iy == i_item.y.cnt - 2'd1);
        z_end   = (r_iz == i_item.z.cnt - 2'd1);
        all_end = x_end && y_end && z_end;
        n_ix    = r_ix;
        n_iy    = r_iy;
        n_iz    = r_iz;
        if (load) begin
            if (all_end) begin
                n_ix = '0;
                n_iy = '0;
                n_iz = '0;
            end else if (z_end) begin
                n_iz = '0;
                if (y_end) begin
                    n_iy = '0;
                    n_ix = r_ix + 2'd1;
                end else begin
                    n_iy = r_iy + 2'd1;
                end
            end else begin
                n_iz = r_iz + 2'd1;
            end
        end
    end

    assign o_pop   = load && all_end;
    assign o_valid = r_out_valid;
    assign o_nbr_x = r_nbr_x;
    assign o_nbr_y = r_nbr_y;
    assign o_nbr_z = r_nbr_z;
    assign o_home  = r_home;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ix        <= '0;
            r_iy        <= '0;
            r_iz        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_ix <= n_ix;
            r_iy <= n_iy;
            r_iz <= n_iz;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_nbr_x <= nce_pkg::pick(i_item.x, r_ix);
            r_nbr_y <= nce_pkg::pick(i_item.y, r_iy);
            r_nbr_z <= nce_pkg::pick(i_item.z, r_iz);
            r_home  <= i_item.home;
            r_last  <= all_end;
        end
    end

endmodule

[tb/testbench.sv]
// testbench for neighbor_cell_enumerator: directed and random home cells, self-checking
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic [nce_pkg::COORD_W-1:0] x;
        logic [nce_pkg::COORD_W-1:0] y;
        logic [nce_pkg::COORD_W-1:0] z;
        logic [nce_pkg::HOME_W-1:0]  home;
        logic                        last;
    } t_nbr_result;

    localparam logic [nce_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_LO =
        nce_pkg::CFG_INDEX_W'(nce_pkg::CFG_PERIODIC_Z + 1);
    localparam logic [nce_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_HI = '1;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_wr_en   = 1'b0;
    logic [nce_pkg::CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [nce_pkg::CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [nce_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [nce_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;

    // shadow of the block's registers
    logic [nce_pkg::SIZE_W-1:0] cells_cfg [3];
    logic                       wrap_cfg  [3];

    t_nbr_result pending_nbrs [$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          error_count   = 0;
    int          cells_sent    = 0;
    int          nbrs_checked  = 0;
    int          configs_used  = 0;

    neighbor_cell_enumerator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // size register 0 behaves as 1, anything past the axis limit as the limit
    function automatic int eff_cells(int axis);
        if (cells_cfg[axis] == '0) begin
            return 1;
        end
        if (cells_cfg[axis] > nce_pkg::MAX_CELLS_PER_AXIS) begin
            return nce_pkg::MAX_CELLS_PER_AXIS;
        end
        return int'(cells_cfg[axis]);
    endfunction

    function automatic void predict_neighbors(input logic [nce_pkg::COORD_W-1:0] cx, cy, cz);
        int          n [3];
        int          h [3];
        int          raw [3];
        int          cand [3][3];
        int          cnt [3];
        int          lx [27];
        int          ly [27];
        int          lz [27];
        int          count;
        int          lo;
        int          hi;
        int          w;
        logic [63:0] home;
        bit          dup;
        t_nbr_result r;
        raw[0] = int'(cx);
        raw[1] = int'(cy);
        raw[2] = int'(cz);
        count  = 0;
        for (int a = 0; a < 3; a++) begin
            n[a]   = eff_cells(a);
            h[a]   = (raw[a] >= n[a]) ? n[a] - 1 : raw[a];
            lo     = h[a] - 1;
            hi     = h[a] + 1;
            cnt[a] = 0;
            if (!wrap_cfg[a]) begin
                if (lo < 0) lo = 0;
                if (hi > n[a] - 1) hi = n[a] - 1;
            end
            for (int v = lo; v <= hi; v++) begin
                w = v;
                if (w == n[a]) w = 0;
                if (w == -1) w = n[a] - 1;
                cand[a][cnt[a]] = w;
                cnt[a]++;
            end
        end
        for (int i = 0; i < cnt[0]; i++) begin
            for (int j = 0; j < cnt[1]; j++) begin
                for (int k = 0; k < cnt[2]; k++) begin
                    dup = 1'b0;
                    for (int m = 0; m < count; m++) begin
                        if (lx[m] == cand[0][i] && ly[m] == cand[1][j] && lz[m] == cand[2][k])
                            dup = 1'b1;
                    end
                    if (!dup) begin
                        lx[count] = cand[0][i];
                        ly[count] = cand[1][j];
                        lz[count] = cand[2][k];
                        count++;
                    end
                end
            end
        end
        home = 64'(h[0]) + 64'(n[0]) * 64'(h[1]) + 64'(n[0]) * 64'(n[1]) * 64'(h[2]);
        for (int m = 0; m < count; m++) begin
            r.x    = nce_pkg::COORD_W'(lx[m]);
            r.y    = nce_pkg::COORD_W'(ly[m]);
            r.z    = nce_pkg::COORD_W'(lz[m]);
            r.home = home[nce_pkg::HOME_W-1:0];
            r.last = (m == count - 1);
            pending_nbrs.push_back(r);
        end
    endfunction

    function automatic void check_field(string what, logic [nce_pkg::HOME_W-1:0] exp_v,
                                        logic [nce_pkg::HOME_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_nbr_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_nbrs.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %h tlast %b",
                         $time, m_axis_tdata, m_axis_tlast);
                error_count++;
            end else begin
                e = pending_nbrs.pop_front();
                check_field("nbr_x", nce_pkg::HOME_W'(e.x),
                            nce_pkg::HOME_W'(m_axis_tdata[nce_pkg::COORD_W-1:0]));
                check_field("nbr_y", nce_pkg::HOME_W'(e.y),
                            nce_pkg::HOME_W'(m_axis_tdata[2*nce_pkg::COORD_W-1:
                                                          nce_pkg::COORD_W]));
                check_field("nbr_z", nce_pkg::HOME_W'(e.z),
                            nce_pkg::HOME_W'(m_axis_tdata[3*nce_pkg::COORD_W-1:
                                                          2*nce_pkg::COORD_W]));
                check_field("home_index", e.home,
                            m_axis_tdata[3*nce_pkg::COORD_W+nce_pkg::HOME_W-1:
                                         3*nce_pkg::COORD_W]);
                check_field("last", nce_pkg::HOME_W'(e.last),
                            nce_pkg::HOME_W'(m_axis_tlast));
                nbrs_checked++;
            end
        end
    end

    // leaves the write enable high, the caller drops it once all writes are done
    task automatic write_reg(input logic [nce_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [nce_pkg::SIZE_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            nce_pkg::CFG_CELLS_X:    cells_cfg[0] = val;
            nce_pkg::CFG_CELLS_Y:    cells_cfg[1] = val;
            nce_pkg::CFG_CELLS_Z:    cells_cfg[2] = val;
            nce_pkg::CFG_PERIODIC_X: wrap_cfg[0]  = val[0];
            nce_pkg::CFG_PERIODIC_Y: wrap_cfg[1]  = val[0];
            nce_pkg::CFG_PERIODIC_Z: wrap_cfg[2]  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [nce_pkg::SIZE_W-1:0] nx, ny, nz,
                              input logic px, py, pz);
        write_reg(nce_pkg::CFG_CELLS_X, nx);
        write_reg(nce_pkg::CFG_CELLS_Y, ny);
        write_reg(nce_pkg::CFG_CELLS_Z, nz);
        write_reg(nce_pkg::CFG_PERIODIC_X, nce_pkg::SIZE_W'(px));
        write_reg(nce_pkg::CFG_PERIODIC_Y, nce_pkg::SIZE_W'(py));
        write_reg(nce_pkg::CFG_PERIODIC_Z, nce_pkg::SIZE_W'(pz));
        i_cfg_wr_en <= 1'b0;
        configs_used++;
    endtask

    // valid stays high after the accept so back-to-back requests need no extra drive
    task automatic send_cell(input logic [nce_pkg::COORD_W-1:0] x, y, z);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(nce_pkg::IN_TDATA_W-3*nce_pkg::COORD_W){1'b0}}, z, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_neighbors(x, y, z);
        cells_sent++;
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_nbrs.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [nce_pkg::SIZE_W-1:0] pick_size();
        int sel;
        sel = $urandom_range(99, 0);
        if (sel < 60) return nce_pkg::SIZE_W'($urandom_range(6, 1));
        if (sel < 85) return nce_pkg::SIZE_W'($urandom_range(64, 7));
        if (sel < 90) return '0;
        return nce_pkg::SIZE_W'($urandom_range(127, 65));
    endfunction

    // edges of the grid get extra weight, a few land beyond it
    function automatic logic [nce_pkg::COORD_W-1:0] pick_coord(int n);
        int sel;
        sel = $urandom_range(99, 0);
        if (sel < 15) return nce_pkg::COORD_W'($urandom_range(63, 0));
        if (sel < 35) return '0;
        if (sel < 55) return nce_pkg::COORD_W'(n - 1);
        return nce_pkg::COORD_W'($urandom_range(n - 1, 0));
    endfunction

    task automatic test_reset_grid();
        send_cell(6'd0, 6'd0, 6'd0);
        send_cell(6'd63, 6'd63, 6'd63);
        wait_drain();
    endtask

    // writes past the last register must leave the grid alone
    task automatic test_unused_index();
        write_reg(CFG_UNUSED_LO, '1);
        write_reg(CFG_UNUSED_HI, '1);
        i_cfg_wr_en <= 1'b0;
        send_cell(6'd5, 6'd5, 6'd5);
        wait_drain();
    endtask

    task automatic test_clamped_corners();
        set_config(7'd64, 7'd64, 7'd64, 1'b0, 1'b0, 1'b0);
        send_cell(6'd0, 6'd0, 6'd0);
        send_cell(6'd63, 6'd63, 6'd63);
        send_cell(6'd32, 6'd32, 6'd32);
        send_cell(6'd31, 6'd0, 6'd63);
        wait_drain();
    endtask

    task automatic test_size_saturation();
        set_config(7'd0, 7'd127, 7'd65, 1'b0, 1'b0, 1'b0);
        send_cell(6'd63, 6'd63, 6'd63);
        send_cell(6'd0, 6'd40, 6'd5);
        send_cell(6'd17, 6'd0, 6'd63);
        wait_drain();
    endtask

    task automatic test_periodic_wrap();
        set_config(7'd5, 7'd5, 7'd5, 1'b1, 1'b1, 1'b1);
        send_cell(6'd0, 6'd0, 6'd0);
        send_cell(6'd4, 6'd4, 6'd4);
        send_cell(6'd2, 6'd2, 6'd2);
        wait_drain();
    endtask

    // one- and two-cell periodic axes produce repeated candidates
    task automatic test_periodic_tiny();
        set_config(7'd1, 7'd2, 7'd3, 1'b1, 1'b1, 1'b1);
        send_cell(6'd0, 6'd0, 6'd0);
        send_cell(6'd0, 6'd1, 6'd2);
        send_cell(6'd63, 6'd63, 6'd63);
        wait_drain();
        set_config(7'd3, 7'd64, 7'd2, 1'b1, 1'b0, 1'b1);
        send_cell(6'd1, 6'd63, 6'd0);
        send_cell(6'd0, 6'd0, 6'd1);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_cells);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n_cells; i++) begin
            if (i % 10 == 0) begin
                wait_drain();
                set_config(pick_size(), pick_size(), pick_size(), 1'($urandom_range(1, 0)),
                           1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
            end
            send_cell(pick_coord(eff_cells(0)), pick_coord(eff_cells(1)),
                      pick_coord(eff_cells(2)));
        end
        wait_drain();
    endtask

    initial begin
        for (int a = 0; a < 3; a++) begin
            cells_cfg[a] = nce_pkg::SIZE_W'(1);
            wrap_cfg[a]  = 1'b0;
        end
        send_idle_pct = 14;
        recv_idle_pct = 67;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_grid();
        test_unused_index();
        test_clamped_corners();
        test_size_saturation();
        test_periodic_wrap();
        test_periodic_tiny();
        test_random_traffic(14, 67, 75);
        test_random_traffic(67, 14, 75);
        test_random_traffic(0, 0, 62);

        wait_drain();
        repeat (10) @(posedge i_clk);
        if (pending_nbrs.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_nbrs.size());
            error_count += pending_nbrs.size();
        end
        $display("run covered %0d home cells under %0d grid settings, %0d neighbors checked",
                 cells_sent, configs_used, nbrs_checked);
        $display("grids from one to 64 cells per axis, clamped and wrapped, with random stalls");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, pending_nbrs.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[neighbor_cell_enumerator.f]
design/nce_pkg.sv
design/nce_front.sv
design/nce_queue.sv
design/nce_back.sv
design/neighbor_cell_enumerator.sv
tb/testbench.sv
